// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker module pse_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pse_pkg.sv -----
// ----------------------------------------------------------------------------
// pse_pkg
// Types, constants and tables of the percentile summary engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int MAX_SAMPLES = 1024;
  localparam int VALUE_W     = 40;
  localparam int FRAC_W      = 17;
  localparam int KIND_W      = 4;
  localparam int NUM_PCT     = 7;
  localparam int PCT_W       = 7;

  localparam logic [FRAC_W-1:0] FRAC_ONE    = 17'h10000;
  localparam logic [PCT_W-1:0]  PCT_ROUND   = 7'd99;

  // floor(x / 100) == (x * PCT_RECIP) >> PCT_SHIFT, exact for x below 14e6
  localparam int                PCT_RECIP_W = 24;
  localparam int                PCT_SHIFT   = 30;
  localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 24'd10737419;

  typedef enum logic [KIND_W-1:0] {
    KIND_MEAN = 4'd0,
    KIND_MIN  = 4'd1,
    KIND_MAX  = 4'd2,
    KIND_P01  = 4'd3,
    KIND_P05  = 4'd4,
    KIND_P10  = 4'd5,
    KIND_P50  = 4'd6,
    KIND_P90  = 4'd7,
    KIND_P95  = 4'd8,
    KIND_P99  = 4'd9
  } stat_kind_e;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SORT_KEY,
    ST_SORT_KEYW,
    ST_SORT_CMP,
    ST_SORT_CMPW,
    ST_RANK_RD,
    ST_RANK_CMP,
    ST_MEAN_DIV,
    ST_MEAN_WAIT,
    ST_MFRAC_DIV,
    ST_MFRAC_WAIT,
    ST_MIN_DIV,
    ST_MIN_WAIT,
    ST_MAX,
    ST_PCT_NEED,
    ST_PCT_IDX,
    ST_PCT_SEL,
    ST_EMIT
  } state_e;

  localparam logic [PCT_W-1:0] PCT_NUM [NUM_PCT] =
    '{7'd1, 7'd5, 7'd10, 7'd50, 7'd90, 7'd95, 7'd99};

  localparam logic [FRAC_W-1:0] PCT_FRAC [NUM_PCT] =
    '{17'd655, 17'd3277, 17'd6554, 17'd32768, 17'd58982, 17'd62259, 17'd64881};

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

// ----- rtl/pse_if.sv -----
// ----------------------------------------------------------------------------
// pse_if
// Valid/ready channels for samples in and statistics out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pse_in_if;
  logic                             valid;
  logic                             ready;
  logic [pse_pkg::SAMPLE_BITS-1:0]  sample;
  logic                             final_sample;

  modport source (output valid, output sample, output final_sample, input ready);
  modport sink   (input valid, input sample, input final_sample, output ready);
endinterface

interface pse_out_if;
  logic                          valid;
  logic                          ready;
  logic [pse_pkg::KIND_W-1:0]    stat_kind;
  logic [pse_pkg::VALUE_W-1:0]   stat_value;
  logic [pse_pkg::FRAC_W-1:0]    cum_fraction;
  logic                          final_result;

  modport source (output valid, output stat_kind, output stat_value,
                  output cum_fraction, output final_result, input ready);
  modport sink   (input valid, input stat_kind, input stat_value,
                  input cum_fraction, input final_result, output ready);
endinterface

`default_nettype wire

// ----- rtl/pse_ram.sv -----
// ----------------------------------------------------------------------------
// pse_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/pse_div.sv -----
// ----------------------------------------------------------------------------
// pse_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_div #(
  parameter int DividendW = 51,
  parameter int DivisorW  = 11
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire pse_pkg::div_ctl_t        ctl_i,
  input  wire logic [DividendW-1:0]     dividend_i,
  input  wire logic [DivisorW-1:0]      divisor_i,
  output pse_pkg::div_sts_t             sts_o,
  output logic      [DividendW-1:0]     quotient_o
);

  localparam int CntW = $clog2(DividendW + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DividendW-1:0] dq_q, dq_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;
  logic [DivisorW:0]    trial;
  logic                 qbit;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, dq_q[DividendW-1]};
    qbit   = (trial >= {1'b0, dvs_q});
    if (busy_q) begin
      rem_d = qbit ? DivisorW'(trial - {1'b0, dvs_q}) : DivisorW'(trial);
      dq_d  = {dq_q[DividendW-2:0], qbit};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DividendW);
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = dq_q;

endmodule

`default_nettype wire

// ----- rtl/percentile_summary_engine.sv -----
// ----------------------------------------------------------------------------
// percentile_summary_engine
// Collects samples, sorts them in place and emits ten summary statistics.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch_i carries one sample per transfer; final_sample closes the set.
//   Loading accepts one sample per cycle. Samples beyond MaxSamples are dropped.
//   After the closing transfer the block drops ready and works alone:
//   insertion sort over the sample RAM (each element move reads the neighbour
//   through the single RAM read port, then writes it one slot up), a rank
//   scan over the sorted samples, then a shared bit-serial divider for the
//   mean, the mean fraction and the min fraction.
//   Each percentile index comes from a reciprocal multiply, followed by a
//   RAM read when the index is inside the set.
//   out_ch_o then gives mean, min, max and the 1/5/10/50/90/95/99
//   percentiles, one result at a time from an output register; a stalled
//   receiver simply holds the sequence. final_result marks the tenth.
//   ready returns in the cycle after the tenth transfer, with sum, min, max
//   and count cleared. Reset clears control state; the RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module percentile_summary_engine #(
  parameter int MaxSamples = pse_pkg::MAX_SAMPLES
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pse_in_if.sink     in_ch_i,
  pse_out_if.source  out_ch_o
);

  localparam int SB   = pse_pkg::SAMPLE_BITS;
  localparam int CW   = $clog2(MaxSamples + 1);
  localparam int AW   = $clog2(MaxSamples);
  localparam int SUMW = SB + CW;
  localparam int DW   = SUMW + 8;
  localparam int VW   = (CW > pse_pkg::PCT_W) ? CW : pse_pkg::PCT_W;
  localparam int VALW = pse_pkg::VALUE_W;
  localparam int FW   = pse_pkg::FRAC_W;
  localparam int NW   = CW + pse_pkg::PCT_W + 1;
  localparam int PW   = NW + pse_pkg::PCT_SHIFT;

  pse_pkg::state_e     state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [SUMW-1:0]     sum_q, sum_d;
  logic [SB-1:0]       min_q, min_d;
  logic [SB-1:0]       max_q, max_d;
  logic [CW-1:0]       i_q, i_d;
  logic [CW-1:0]       j_q, j_d;
  logic [CW-1:0]       rank_q, rank_d;
  logic [SB-1:0]       key_q, key_d;
  logic [VALW-1:0]     mean_q, mean_d;
  logic [2:0]          pidx_q, pidx_d;
  logic [NW-1:0]       need_q, need_d;

  logic                ov_q, ov_d;
  pse_pkg::stat_kind_e okind_q, okind_d;
  logic [VALW-1:0]     oval_q, oval_d;
  logic [FW-1:0]       ofrac_q, ofrac_d;
  logic                ofin_q, ofin_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SB-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [SB-1:0]       ram_rdata;

  pse_pkg::div_ctl_t   div_ctl;
  pse_pkg::div_sts_t   div_sts;
  logic [DW-1:0]       div_dividend;
  logic [VW-1:0]       div_divisor;
  logic [DW-1:0]       div_quot;

  logic [SB-1:0]       smp;
  logic                full;
  logic [CW-1:0]       jm1;
  logic [SUMW-1:0]     rank_prod;
  logic [NW-1:0]       pct_need;
  logic [PW-1:0]       pct_prod;
  logic [NW-1:0]       pct_idx;
  logic [CW+16:0]      mfrac_num;

  assign smp       = in_ch_i.sample;
  assign full      = (count_q == CW'(MaxSamples));
  assign jm1       = j_q - CW'(1);
  assign rank_prod = SUMW'(count_q) * SUMW'(ram_rdata);
  assign pct_need  = NW'(count_q * pse_pkg::PCT_NUM[pidx_q])
                   + NW'(pse_pkg::PCT_ROUND);
  // ceil(n*p/100) as floor((n*p+99)/100) by reciprocal multiplication
  assign pct_prod  = PW'(need_q) * PW'(pse_pkg::PCT_RECIP);
  assign pct_idx   = pct_prod[PW-1:pse_pkg::PCT_SHIFT];
  assign mfrac_num = {(CW+1)'(rank_q) + (CW+1)'(1), 16'h0000};

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    sum_d    = sum_q;
    min_d    = min_q;
    max_d    = max_q;
    i_d      = i_q;
    j_d      = j_q;
    rank_d   = rank_q;
    key_d    = key_q;
    mean_d   = mean_q;
    pidx_d   = pidx_q;
    need_d   = need_q;
    ov_d     = ov_q;
    okind_d  = okind_q;
    oval_d   = oval_q;
    ofrac_d  = ofrac_q;
    ofin_d   = ofin_q;
    ram_we   = 1'b0;
    ram_waddr = j_q[AW-1:0];
    ram_wdata = key_q;
    ram_raddr = i_q[AW-1:0];
    div_ctl.start = 1'b0;
    div_dividend  = {sum_q, 8'h00};
    div_divisor   = VW'(count_q);

    unique case (state_q)
      pse_pkg::ST_LOAD: begin
        if (in_ch_i.valid) begin
          if (!full) begin
            ram_we    = 1'b1;
            ram_waddr = count_q[AW-1:0];
            ram_wdata = smp;
            sum_d     = sum_q + SUMW'(smp);
            count_d   = count_q + CW'(1);
            if (count_q == '0) begin
              min_d = smp;
              max_d = smp;
            end else begin
              if (smp < min_q) min_d = smp;
              if (smp > max_q) max_d = smp;
            end
          end
          if (in_ch_i.final_sample) begin
            i_d     = CW'(1);
            state_d = pse_pkg::ST_SORT_KEY;
          end
        end
      end
      pse_pkg::ST_SORT_KEY: begin
        if (i_q >= count_q) begin
          rank_d  = '0;
          state_d = pse_pkg::ST_RANK_RD;
        end else begin
          ram_raddr = i_q[AW-1:0];
          state_d   = pse_pkg::ST_SORT_KEYW;
        end
      end
      pse_pkg::ST_SORT_KEYW: begin
        key_d   = ram_rdata;
        j_d     = i_q;
        state_d = pse_pkg::ST_SORT_CMP;
      end
      pse_pkg::ST_SORT_CMP: begin
        if (j_q == '0) begin
          ram_we  = 1'b1;
          i_d     = i_q + CW'(1);
          state_d = pse_pkg::ST_SORT_KEY;
        end else begin
          ram_raddr = jm1[AW-1:0];
          state_d   = pse_pkg::ST_SORT_CMPW;
        end
      end
      pse_pkg::ST_SORT_CMPW: begin
        ram_we = 1'b1;
        if (ram_rdata > key_q) begin
          // shift the larger neighbor up one slot
          ram_wdata = ram_rdata;
          j_d       = jm1;
          state_d   = pse_pkg::ST_SORT_CMP;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = pse_pkg::ST_SORT_KEY;
        end
      end
      pse_pkg::ST_RANK_RD: begin
        ram_raddr = rank_q[AW-1:0];
        state_d   = pse_pkg::ST_RANK_CMP;
      end
      pse_pkg::ST_RANK_CMP: begin
        if (rank_prod >= sum_q || rank_q == count_q - CW'(1)) begin
          state_d = pse_pkg::ST_MEAN_DIV;
        end else begin
          rank_d  = rank_q + CW'(1);
          state_d = pse_pkg::ST_RANK_RD;
        end
      end
      pse_pkg::ST_MEAN_DIV: begin
        div_ctl.start = 1'b1;
        state_d       = pse_pkg::ST_MEAN_WAIT;
      end
      pse_pkg::ST_MEAN_WAIT: begin
        if (div_sts.done) begin
          mean_d  = div_quot[VALW-1:0];
          state_d = pse_pkg::ST_MFRAC_DIV;
        end
      end
      pse_pkg::ST_MFRAC_DIV: begin
        div_ctl.start = 1'b1;
        div_dividend  = DW'(mfrac_num);
        state_d       = pse_pkg::ST_MFRAC_WAIT;
      end
      pse_pkg::ST_MFRAC_WAIT: begin
        if (div_sts.done) begin
          ov_d    = 1'b1;
          okind_d = pse_pkg::KIND_MEAN;
          oval_d  = mean_q;
          ofrac_d = div_quot[FW-1:0];
          ofin_d  = 1'b0;
          state_d = pse_pkg::ST_EMIT;
        end
      end
      pse_pkg::ST_MIN_DIV: begin
        div_ctl.start = 1'b1;
        div_dividend  = DW'(pse_pkg::FRAC_ONE);
        state_d       = pse_pkg::ST_MIN_WAIT;
      end
      pse_pkg::ST_MIN_WAIT: begin
        if (div_sts.done) begin
          ov_d    = 1'b1;
          okind_d = pse_pkg::KIND_MIN;
          oval_d  = VALW'({min_q, 8'h00});
          ofrac_d = div_quot[FW-1:0];
          ofin_d  = 1'b0;
          state_d = pse_pkg::ST_EMIT;
        end
      end
      pse_pkg::ST_MAX: begin
        ov_d    = 1'b1;
        okind_d = pse_pkg::KIND_MAX;
        oval_d  = VALW'({max_q, 8'h00});
        ofrac_d = pse_pkg::FRAC_ONE;
        ofin_d  = 1'b0;
        state_d = pse_pkg::ST_EMIT;
      end
      pse_pkg::ST_PCT_NEED: begin
        need_d  = pct_need;
        state_d = pse_pkg::ST_PCT_IDX;
      end
      pse_pkg::ST_PCT_IDX: begin
        okind_d = pse_pkg::stat_kind_e'(pse_pkg::KIND_W'(pse_pkg::KIND_P01)
                                        + pse_pkg::KIND_W'(pidx_q));
        ofrac_d = pse_pkg::PCT_FRAC[pidx_q];
        ofin_d  = (pidx_q == 3'(pse_pkg::NUM_PCT - 1));
        if (pct_idx < NW'(count_q)) begin
          ram_raddr = pct_idx[AW-1:0];
          state_d   = pse_pkg::ST_PCT_SEL;
        end else begin
          // no qualifying element: report the max
          ov_d    = 1'b1;
          oval_d  = VALW'({max_q, 8'h00});
          state_d = pse_pkg::ST_EMIT;
        end
      end
      pse_pkg::ST_PCT_SEL: begin
        ov_d    = 1'b1;
        oval_d  = VALW'({ram_rdata, 8'h00});
        state_d = pse_pkg::ST_EMIT;
      end
      pse_pkg::ST_EMIT: begin
        if (out_ch_o.ready) begin
          ov_d = 1'b0;
          unique case (okind_q)
            pse_pkg::KIND_MEAN: state_d = pse_pkg::ST_MIN_DIV;
            pse_pkg::KIND_MIN:  state_d = pse_pkg::ST_MAX;
            pse_pkg::KIND_MAX: begin
              pidx_d  = '0;
              state_d = pse_pkg::ST_PCT_NEED;
            end
            default: begin
              if (ofin_q) begin
                count_d = '0;
                sum_d   = '0;
                min_d   = '0;
                max_d   = '0;
                state_d = pse_pkg::ST_LOAD;
              end else begin
                pidx_d  = pidx_q + 3'd1;
                state_d = pse_pkg::ST_PCT_NEED;
              end
            end
          endcase
        end
      end
      default: state_d = pse_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pse_pkg::ST_LOAD;
      count_q <= '0;
      sum_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      min_q   <= min_d;
      max_q   <= max_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    rank_q  <= rank_d;
    key_q   <= key_d;
    mean_q  <= mean_d;
    pidx_q  <= pidx_d;
    need_q  <= need_d;
    okind_q <= okind_d;
    oval_q  <= oval_d;
    ofrac_q <= ofrac_d;
    ofin_q  <= ofin_d;
  end

  pse_ram #(
    .Width (SB),
    .Depth (MaxSamples)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pse_div #(
    .DividendW (DW),
    .DivisorW  (VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quotient_o (div_quot)
  );

  assign in_ch_i.ready         = (state_q == pse_pkg::ST_LOAD);
  assign out_ch_o.valid        = ov_q;
  assign out_ch_o.stat_kind    = okind_q;
  assign out_ch_o.stat_value   = oval_q;
  assign out_ch_o.cum_fraction = ofrac_q;
  assign out_ch_o.final_result = ofin_q;

endmodule

`default_nettype wire

// ----- rtl/pse_checker.sv -----
// ----------------------------------------------------------------------------
// pse_checker
// Port-level assertions for the percentile summary engine.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pse_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [pse_pkg::KIND_W-1:0]    out_kind_i,
  input wire logic                          out_final_i
);

  // results are only offered while no new samples are taken
  `ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid_i, !in_ready_i,
              "sample accepted while a result is pending")

  `ASSERT_IMP(a_final_kind, clk_i, rst_ni, out_valid_i && out_final_i,
              out_kind_i == pse_pkg::KIND_P99, "final result is not the 99th percentile")

  `ASSERT_NXT(a_ready_after_set, clk_i, rst_ni,
              out_valid_i && out_ready_i && out_final_i, in_ready_i,
              "not ready after last result transfer")

  `ASSERT_NXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
              out_valid_i && $stable(out_kind_i), "stalled result changed")

  // a result offered just after a sample is taken must be the mean
  `ASSERT_NXT(a_mean_first, clk_i, rst_ni,
              in_valid_i && in_ready_i, !out_valid_i || out_kind_i == pse_pkg::KIND_MEAN,
              "result sequence does not start with the mean")

endmodule

bind percentile_summary_engine pse_checker u_pse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch_i.valid),
  .in_ready_i  (in_ch_i.ready),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .out_kind_i  (out_ch_o.stat_kind),
  .out_final_i (out_ch_o.final_result)
);

`default_nettype wire
